// ----- hw/rtl/i2p_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, codes and precedence helpers for the infix-to-postfix
// converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int CODE_W      = 3;

   // Input token kinds.
   localparam logic [2:0] KIND_OPERAND  = 3'd0;
   localparam logic [2:0] KIND_OPERATOR = 3'd1;
   localparam logic [2:0] KIND_OPEN     = 3'd2;
   localparam logic [2:0] KIND_CLOSE    = 3'd3;
   localparam logic [2:0] KIND_END      = 3'd4;

   // Operator codes, plus the open-bracket marker kept on the stack.
   localparam logic [CODE_W-1:0] OP_ADD    = 3'd0;
   localparam logic [CODE_W-1:0] OP_SUB    = 3'd1;
   localparam logic [CODE_W-1:0] OP_MUL    = 3'd2;
   localparam logic [CODE_W-1:0] OP_DIV    = 3'd3;
   localparam logic [CODE_W-1:0] OP_POW    = 3'd4;
   localparam logic [CODE_W-1:0] OP_MARKER = 3'd5;

   // Result kinds.
   localparam logic [1:0] OUT_OPERAND  = 2'd0;
   localparam logic [1:0] OUT_OPERATOR = 2'd1;
   localparam logic [1:0] OUT_END      = 2'd2;

   // Error codes.
   localparam logic [1:0] ERR_NONE            = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW        = 2'd1;
   localparam logic [1:0] ERR_UNMATCHED_CLOSE = 2'd2;
   localparam logic [1:0] ERR_UNMATCHED_OPEN  = 2'd3;

   typedef struct packed {
      logic [2:0]  token_kind;
      logic [2:0]  operator_code;
      logic [63:0] operand_value;
      logic        operand_is_variable;
   } req_type;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [2:0]  out_operator;
      logic [63:0] out_value;
      logic        out_is_variable;
      logic [1:0]  error_code;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic              push;
      logic              pop;
      logic [CODE_W-1:0] code;
   } stack_ctl_type;

   typedef struct packed {
      logic [CNT_W-1:0]  count;
      logic [CODE_W-1:0] top;
      logic [CODE_W-1:0] second;
   } stack_stat_type;

   function automatic logic [1:0] prec_of(logic [CODE_W-1:0] op);
      logic [1:0] p;
      if (op <= OP_SUB) begin
         p = 2'd1;
      end else if (op <= OP_DIV) begin
         p = 2'd2;
      end else begin
         p = 2'd3;
      end
      return p;
   endfunction

   // True when the stacked entry must be emitted before the incoming operator
   // is pushed. Power is right-associative, so it only yields to tighter ones.
   function automatic logic should_pop(logic [CODE_W-1:0] op, logic [CODE_W-1:0] t);
      logic [1:0] p_in;
      logic [1:0] p_top;
      logic       res;
      p_in  = prec_of(op);
      p_top = prec_of(t);
      if (t == OP_MARKER) begin
         res = 1'b0;
      end else if (op == OP_POW) begin
         res = (p_in < p_top);
      end else begin
         res = (p_in <= p_top);
      end
      return res;
   endfunction

endpackage

// ----- hw/rtl/i2p_stack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_stack
// Operator stack built as a shift line: the top entry always sits at index
// zero, so the top and the entry below it are read at fixed places.
// ----------------------------------------------------------------------------
module i2p_stack (
   input  logic                    clock,
   input  logic                    reset,
   input  i2p_pkg::stack_ctl_type  ctl,
   output i2p_pkg::stack_stat_type stat
);
   import i2p_pkg::*;

   logic [CODE_W-1:0] entry_ff [STACK_DEPTH];
   logic [CODE_W-1:0] entry_in [STACK_DEPTH];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   always_comb begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
         entry_in[i] = entry_ff[i];
      end
      count_in = count_ff;
      if (ctl.push) begin
         entry_in[0] = ctl.code;
         for (int i = 1; i < STACK_DEPTH; i++) begin
            entry_in[i] = entry_ff[i-1];
         end
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         for (int i = 0; i < STACK_DEPTH - 1; i++) begin
            entry_in[i] = entry_ff[i+1];
         end
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.count  = count_ff;
   assign stat.top    = entry_ff[0];
   assign stat.second = entry_ff[1];

endmodule

// ----- hw/rtl/infix_to_postfix_converter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: takes infix tokens and emits them in postfix order
// through an operator stack, one step per cycle unless the response stalls.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Direction  Carries
//  request   req_valid/req_ready/req_data   in         one infix token
//  response  rsp_valid/rsp_ready/rsp_data   out        one postfix token
//
//  An operand or open bracket is handled in the cycle it is accepted.
//  The sequencer moves one stack entry per cycle while the output register
//  is free: an operator or close bracket pops what it releases, then pushes
//  the operator or drops the marker; the end token empties the stack first.
//  A stalled response holds the sequencer; the next request is taken once the
//  token is finished and the output register is free.
//  Reset empties the stack by clearing its count; entries need no clearing.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  i2p_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output i2p_pkg::rsp_type rsp_data
);
   import i2p_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_OPER  = 2'd1;
   localparam logic [1:0] S_CLOSE = 2'd2;
   localparam logic [1:0] S_END   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CODE_W-1:0] tok_op_ff, tok_op_in;
   logic              open_ff, open_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff;
   logic              emit;
   logic              out_free;
   logic              accept;
   logic              full;
   logic              have_two;
   stack_ctl_type     stk_ctl;
   stack_stat_type    stk_stat;

   i2p_stack u_stack (
      .clock (clock),
      .reset (reset),
      .ctl   (stk_ctl),
      .stat  (stk_stat)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign full      = (stk_stat.count == CNT_W'(STACK_DEPTH));
   assign have_two  = (stk_stat.count > CNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      tok_op_in    = tok_op_ff;
      open_in      = open_ff;
      emit         = 1'b0;
      rsp_in       = '0;
      stk_ctl.push = 1'b0;
      stk_ctl.pop  = 1'b0;
      stk_ctl.code = tok_op_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.token_kind)
                  KIND_OPERAND: begin
                     emit                   = 1'b1;
                     rsp_in.out_kind        = OUT_OPERAND;
                     rsp_in.out_value       = req_data.operand_value;
                     rsp_in.out_is_variable = req_data.operand_is_variable;
                     rsp_in.last_of_run     = 1'b1;
                  end
                  KIND_OPERATOR: begin
                     if (req_data.operator_code <= OP_POW) begin
                        tok_op_in = req_data.operator_code;
                        state_in  = S_OPER;
                     end
                  end
                  KIND_OPEN: begin
                     if (full) begin
                        emit               = 1'b1;
                        rsp_in.out_kind    = OUT_OPERATOR;
                        rsp_in.error_code  = ERR_OVERFLOW;
                        rsp_in.last_of_run = 1'b1;
                     end else begin
                        stk_ctl.push = 1'b1;
                        stk_ctl.code = OP_MARKER;
                     end
                  end
                  KIND_CLOSE: begin
                     state_in = S_CLOSE;
                  end
                  KIND_END: begin
                     open_in  = 1'b0;
                     state_in = S_END;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_OPER: begin
            if (out_free) begin
               if (stk_stat.count != '0 && should_pop(tok_op_ff, stk_stat.top)) begin
                  // The push after the pops cannot overflow, so this is the
                  // last result unless the entry below also has to go.
                  emit                = 1'b1;
                  rsp_in.out_kind     = OUT_OPERATOR;
                  rsp_in.out_operator = stk_stat.top;
                  rsp_in.last_of_run  = !(have_two && should_pop(tok_op_ff, stk_stat.second));
                  stk_ctl.pop         = 1'b1;
               end else if (full) begin
                  emit               = 1'b1;
                  rsp_in.out_kind    = OUT_OPERATOR;
                  rsp_in.error_code  = ERR_OVERFLOW;
                  rsp_in.last_of_run = 1'b1;
                  state_in           = S_IDLE;
               end else begin
                  stk_ctl.push = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end
         S_CLOSE: begin
            if (out_free) begin
               if (stk_stat.count == '0) begin
                  emit               = 1'b1;
                  rsp_in.out_kind    = OUT_OPERATOR;
                  rsp_in.error_code  = ERR_UNMATCHED_CLOSE;
                  rsp_in.last_of_run = 1'b1;
                  state_in           = S_IDLE;
               end else if (stk_stat.top == OP_MARKER) begin
                  stk_ctl.pop = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  emit                = 1'b1;
                  rsp_in.out_kind     = OUT_OPERATOR;
                  rsp_in.out_operator = stk_stat.top;
                  rsp_in.last_of_run  = have_two && (stk_stat.second == OP_MARKER);
                  stk_ctl.pop         = 1'b1;
               end
            end
         end
         S_END: begin
            if (out_free) begin
               if (stk_stat.count == '0) begin
                  emit               = 1'b1;
                  rsp_in.out_kind    = OUT_END;
                  rsp_in.error_code  = open_ff ? ERR_UNMATCHED_OPEN : ERR_NONE;
                  rsp_in.last_of_run = 1'b1;
                  state_in           = S_IDLE;
               end else if (stk_stat.top == OP_MARKER) begin
                  stk_ctl.pop = 1'b1;
                  open_in     = 1'b1;
               end else begin
                  emit                = 1'b1;
                  rsp_in.out_kind     = OUT_OPERATOR;
                  rsp_in.out_operator = stk_stat.top;
                  stk_ctl.pop         = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         open_ff  <= open_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      tok_op_ff <= tok_op_in;
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stk_stat.count <= CNT_W'(STACK_DEPTH))
      else $error("operator stack count beyond depth");

   a_no_empty_pop: assert property (@(posedge clock) disable iff (reset)
      stk_ctl.pop |-> stk_stat.count != '0)
      else $error("pop from an empty operator stack");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready)
      else $error("request taken while a token is still in work");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_kind == OUT_END |-> rsp_data.last_of_run)
      else $error("end marker not flagged as last of run");

endmodule

// ----- tb/sv/infix_to_postfix_converter_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_test
// Self-checking bench for the shunting-yard converter. A short directed
// drill is followed by random expressions, most of them well formed, mixed
// with stray tokens. A behavioral operator stack predicts the postfix tokens
// of all but the typed drill rows, and each response is compared field by
// field as it is taken. Both channels see random stalls.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_test;
   import i2p_pkg::*;

   localparam int RANDOM_ITEMS = 210;
   localparam int IDLE_LIMIT   = 2000;
   localparam int SETTLE       = 40;

   typedef struct {
      req_type token;
      int      copies;
      bit      typed;
      rsp_type want;
   } drill_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic [2:0]    op_stack [STACK_DEPTH];
   int            op_depth = 0;
   rsp_type       step_out[$];
   rsp_type       postfix_expected[$];
   drill_row_type drill[$];

   int fail_count   = 0;
   int idle_cycles  = 0;
   int tokens_sent  = 0;
   int sink_stall   = 0;
   bit source_quiet = 1'b0;
   bit sink_quiet   = 1'b0;

   infix_to_postfix_converter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 40);
   endfunction

   function automatic req_type tok(logic [2:0] kind, logic [2:0] op,
                                   logic [63:0] value, logic is_var);
      req_type t;
      t.token_kind          = kind;
      t.operator_code       = op;
      t.operand_value       = value;
      t.operand_is_variable = is_var;
      return t;
   endfunction

   // Fields that the token kind does not use are filled with noise.
   function automatic req_type scrambled(logic [2:0] kind, logic [2:0] op);
      return tok(kind, op, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
   endfunction

   function automatic rsp_type postfix_token(logic [1:0] kind, logic [2:0] op,
                                             logic [63:0] value, logic is_var,
                                             logic [1:0] err);
      rsp_type r;
      r.out_kind        = kind;
      r.out_operator    = op;
      r.out_value       = value;
      r.out_is_variable = is_var;
      r.error_code      = err;
      r.last_of_run     = 1'b0;
      return r;
   endfunction

   function automatic rsp_type lone(rsp_type r);
      r.last_of_run = 1'b1;
      return r;
   endfunction

   function automatic int tightness(logic [2:0] op);
      if (op <= OP_SUB) begin
         return 1;
      end else if (op <= OP_DIV) begin
         return 2;
      end
      return 3;
   endfunction

   function automatic bit ignored_token(req_type t);
      return t.token_kind > KIND_END ||
             (t.token_kind == KIND_OPERATOR && t.operator_code > OP_POW);
   endfunction

   // Shunting-yard step: fills step_out with the postfix tokens released.
   task automatic convert_token(input req_type t);
      logic [2:0] top;
      bit         found;
      bit         yields;
      rsp_type    tail;
      step_out.delete();
      case (t.token_kind)
         KIND_OPERAND: begin
            step_out.push_back(postfix_token(OUT_OPERAND, '0, t.operand_value,
                                             t.operand_is_variable, ERR_NONE));
         end
         KIND_OPERATOR: begin
            if (t.operator_code <= OP_POW) begin
               while (op_depth > 0) begin
                  top = op_stack[op_depth - 1];
                  if (top == OP_MARKER) break;
                  // Power is right-associative and only yields to tighter ones.
                  if (t.operator_code == OP_POW) begin
                     yields = tightness(t.operator_code) < tightness(top);
                  end else begin
                     yields = tightness(t.operator_code) <= tightness(top);
                  end
                  if (!yields) break;
                  step_out.push_back(postfix_token(OUT_OPERATOR, top, '0, 1'b0,
                                                   ERR_NONE));
                  op_depth--;
               end
               if (op_depth < STACK_DEPTH) begin
                  op_stack[op_depth] = t.operator_code;
                  op_depth++;
               end else begin
                  step_out.push_back(postfix_token(OUT_OPERATOR, '0, '0, 1'b0,
                                                   ERR_OVERFLOW));
               end
            end
         end
         KIND_OPEN: begin
            if (op_depth < STACK_DEPTH) begin
               op_stack[op_depth] = OP_MARKER;
               op_depth++;
            end else begin
               step_out.push_back(postfix_token(OUT_OPERATOR, '0, '0, 1'b0,
                                                ERR_OVERFLOW));
            end
         end
         KIND_CLOSE: begin
            found = 1'b0;
            while (op_depth > 0) begin
               op_depth--;
               top = op_stack[op_depth];
               if (top == OP_MARKER) begin
                  found = 1'b1;
                  break;
               end
               step_out.push_back(postfix_token(OUT_OPERATOR, top, '0, 1'b0,
                                                ERR_NONE));
            end
            if (!found) begin
               step_out.push_back(postfix_token(OUT_OPERATOR, '0, '0, 1'b0,
                                                ERR_UNMATCHED_CLOSE));
            end
         end
         KIND_END: begin
            found = 1'b0;
            while (op_depth > 0) begin
               op_depth--;
               top = op_stack[op_depth];
               if (top == OP_MARKER) begin
                  found = 1'b1;
               end else begin
                  step_out.push_back(postfix_token(OUT_OPERATOR, top, '0, 1'b0,
                                                   ERR_NONE));
               end
            end
            step_out.push_back(postfix_token(OUT_END, '0, '0, 1'b0,
                                             found ? ERR_UNMATCHED_OPEN : ERR_NONE));
         end
         default: ;
      endcase
      if (step_out.size() > 0) begin
         tail = step_out.pop_back();
         tail.last_of_run = 1'b1;
         step_out.push_back(tail);
      end
   endtask

   // Holds the request until it is taken, then predicts and maybe idles.
   task automatic present_token(input req_type t, input bit typed, input rsp_type want);
      int gap;
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!req_ready);
      convert_token(t);
      if (typed) begin
         postfix_expected.push_back(want);
      end else begin
         foreach (step_out[i]) postfix_expected.push_back(step_out[i]);
      end
      if (!ignored_token(t)) tokens_sent++;
      gap = pick_gap(source_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send(input req_type t);
      present_token(t, 1'b0, '0);
   endtask

   task automatic hold_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (postfix_expected.size() != 0);
   endtask

   task automatic random_expression(input bit deep);
      int  nest;
      int  len;
      int  c;
      bit  want_operand;
      bit  done;
      logic [2:0] op;
      nest         = 0;
      len          = 0;
      want_operand = 1'b1;
      done         = 1'b0;
      while (!done) begin
         len++;
         if ($urandom_range(0, 99) < 4) begin
            send(scrambled(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))));
         end else if (want_operand) begin
            if (nest < (deep ? 30 : 4) && $urandom_range(0, 99) < (deep ? 60 : 25)) begin
               send(scrambled(KIND_OPEN, 3'($urandom_range(0, 7))));
               nest++;
            end else begin
               send(scrambled(KIND_OPERAND, 3'($urandom_range(0, 7))));
               want_operand = 1'b0;
            end
         end else begin
            c = $urandom_range(0, 99);
            if (nest > 0 && c < 30) begin
               send(scrambled(KIND_CLOSE, 3'($urandom_range(0, 7))));
               nest--;
            end else if (c >= 80 || len > 40) begin
               // Leaving brackets open here exercises the unmatched open path.
               send(scrambled(KIND_END, 3'($urandom_range(0, 7))));
               done = 1'b1;
            end else begin
               if (deep && $urandom_range(0, 9) < 7) begin
                  op = OP_POW;
               end else begin
                  op = 3'($urandom_range(OP_ADD, OP_POW));
               end
               send(scrambled(KIND_OPERATOR, op));
               want_operand = 1'b1;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin : check_postfix
      rsp_type want;
      if (rsp_valid && rsp_ready) begin
         if (postfix_expected.size() == 0) begin
            $error("unexpected postfix token %p", rsp_data);
            fail_count++;
         end else begin
            want = postfix_expected.pop_front();
            if (rsp_data.out_kind !== want.out_kind) begin
               $error("out_kind: expected %0d, got %0d", want.out_kind, rsp_data.out_kind);
               fail_count++;
            end
            if (rsp_data.out_operator !== want.out_operator) begin
               $error("out_operator: expected %0d, got %0d",
                      want.out_operator, rsp_data.out_operator);
               fail_count++;
            end
            if (rsp_data.out_value !== want.out_value) begin
               $error("out_value: expected %h, got %h", want.out_value, rsp_data.out_value);
               fail_count++;
            end
            if (rsp_data.out_is_variable !== want.out_is_variable) begin
               $error("out_is_variable: expected %0d, got %0d",
                      want.out_is_variable, rsp_data.out_is_variable);
               fail_count++;
            end
            if (rsp_data.error_code !== want.error_code) begin
               $error("error_code: expected %0d, got %0d",
                      want.error_code, rsp_data.error_code);
               fail_count++;
            end
            if (rsp_data.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0d, got %0d",
                      want.last_of_run, rsp_data.last_of_run);
               fail_count++;
            end
         end
      end
      if ($urandom_range(0, 63) == 0) sink_quiet = !sink_quiet;
      if (sink_stall > 0) begin
         rsp_ready <= 1'b0;
         sink_stall--;
      end else begin
         rsp_ready <= 1'b1;
         sink_stall = pick_gap(sink_quiet);
      end
   end

   initial begin : stimulus
      int r;
      // Typed rows give a single token each: the first three start from an empty stack, the last two from brackets.
      drill.push_back('{tok(KIND_OPERAND, OP_POW, '1, 1'b1), 1, 1'b1,
                        lone(postfix_token(OUT_OPERAND, '0, '1, 1'b1, ERR_NONE))});
      drill.push_back('{tok(KIND_CLOSE, OP_ADD, '0, 1'b0), 1, 1'b1,
                        lone(postfix_token(OUT_OPERATOR, '0, '0, 1'b0,
                                           ERR_UNMATCHED_CLOSE))});
      drill.push_back('{tok(KIND_END, OP_ADD, '0, 1'b0), 1, 1'b1,
                        lone(postfix_token(OUT_END, '0, '0, 1'b0, ERR_NONE))});
      // ( 0 + x ) * 3 ^ 4 ^ 5 - 6 / <bad operator> <bad kind> g <end>
      drill.push_back('{tok(KIND_OPEN, OP_ADD, '0, 1'b0), 1, 1'b0, '0});
      drill.push_back('{tok(KIND_OPERAND, OP_ADD, '0, 1'b0), 1, 1'b0, '0});
      drill.push_back('{tok(KIND_OPERATOR, OP_ADD, '0, 1'b0), 1, 1'b0, '0});
      drill.push_back('{tok(KIND_OPERAND, OP_ADD, 64'h78, 1'b1), 1, 1'b0, '0});
      drill.push_back('{tok(KIND_CLOSE, OP_ADD, '0, 1'b0), 1, 1'b0, '0});
      drill.push_back('{tok(KIND_OPERATOR, OP_MUL, '0, 1'b0), 1, 1'b0, '0});
      drill.push_back('{tok(KIND_OPERAND, OP_ADD, 64'h3, 1'b0), 1, 1'b0, '0});
      drill.push_back('{tok(KIND_OPERATOR, OP_POW, '0, 1'b0), 1, 1'b0, '0});
      drill.push_back('{tok(KIND_OPERAND, OP_ADD, 64'h4, 1'b0), 1, 1'b0, '0});
      drill.push_back('{tok(KIND_OPERATOR, OP_POW, '0, 1'b0), 1, 1'b0, '0});
      drill.push_back('{tok(KIND_OPERAND, OP_ADD, 64'h5, 1'b0), 1, 1'b0, '0});
      drill.push_back('{tok(KIND_OPERATOR, OP_SUB, '0, 1'b0), 1, 1'b0, '0});
      drill.push_back('{tok(KIND_OPERAND, OP_ADD, 64'h6, 1'b0), 1, 1'b0, '0});
      drill.push_back('{tok(KIND_OPERATOR, OP_DIV, '0, 1'b0), 1, 1'b0, '0});
      drill.push_back('{tok(KIND_OPERATOR, 3'd7, '0, 1'b0), 1, 1'b0, '0});
      drill.push_back('{tok(3'd7, OP_ADD, '1, 1'b1), 1, 1'b0, '0});
      drill.push_back('{tok(KIND_OPERAND, OP_ADD, 64'h7, 1'b1), 1, 1'b0, '0});
      drill.push_back('{tok(KIND_END, OP_ADD, '0, 1'b0), 1, 1'b0, '0});
      // Fill the stack with brackets, then one more overflows.
      drill.push_back('{tok(KIND_OPEN, OP_ADD, '0, 1'b0), STACK_DEPTH, 1'b0, '0});
      drill.push_back('{tok(KIND_OPEN, OP_ADD, '0, 1'b0), 1, 1'b1,
                        lone(postfix_token(OUT_OPERATOR, '0, '0, 1'b0, ERR_OVERFLOW))});
      drill.push_back('{tok(KIND_END, OP_ADD, '0, 1'b0), 1, 1'b1,
                        lone(postfix_token(OUT_END, '0, '0, 1'b0, ERR_UNMATCHED_OPEN))});

      while (reset) @(posedge clock);
      foreach (drill[i]) begin
         repeat (drill[i].copies) present_token(drill[i].token, drill[i].typed, drill[i].want);
      end
      hold_for_drain();

      while (tokens_sent < RANDOM_ITEMS) begin
         source_quiet = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 9) == 0) hold_for_drain();
         r = $urandom_range(0, 9);
         if (r < 8) begin
            random_expression(r == 0);
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send(scrambled(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))));
            end
         end
      end

      hold_for_drain();
      repeat (SETTLE) @(posedge clock);
      if (postfix_expected.size() != 0) begin
         $error("%0d postfix tokens never arrived", postfix_expected.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- infix_to_postfix_converter.f -----
hw/rtl/i2p_pkg.sv
hw/rtl/i2p_stack.sv
hw/rtl/infix_to_postfix_converter.sv
tb/sv/infix_to_postfix_converter_test.sv
